// ===== hw/rtl/bul_pkg.sv =====
// Shared types and constants for the battery usage statistics logger.
// No dependencies; compile first.
package bul_pkg;

  // Default width of the minute totals and the operating run counter.
  localparam int unsigned BUL_COUNTER_WIDTH = 32;
  localparam int unsigned BUL_STAT_WIDTH    = 32;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_READ = 1'b1
  } bul_req_type_e;

  typedef enum logic [2:0] {
    REG_CHG_THR   = 3'd0,
    REG_DIS_THR   = 3'd1,
    REG_LOW_LIM   = 3'd2,
    REG_XLOW_LIM  = 3'd3,
    REG_HIGH_LIM  = 3'd4,
    REG_XHIGH_LIM = 3'd5,
    REG_TPM       = 3'd6,
    REG_SETTLE    = 3'd7
  } bul_cfg_reg_e;

  typedef enum logic [4:0] {
    STAT_OP_TOTAL    = 5'd0,
    STAT_OP_LAST     = 5'd1,
    STAT_OP_LONGEST  = 5'd2,
    STAT_CHG_TOTAL   = 5'd3,
    STAT_FULL_COUNT  = 5'd4,
    STAT_CHG_LOW     = 5'd5,
    STAT_CHG_HIGH    = 5'd6,
    STAT_CHG_XLOW    = 5'd7,
    STAT_CHG_XHIGH   = 5'd8,
    STAT_DIS_TOTAL   = 5'd9,
    STAT_EMPTY_COUNT = 5'd10,
    STAT_DIS_LOW     = 5'd11,
    STAT_DIS_HIGH    = 5'd12,
    STAT_DIS_XLOW    = 5'd13,
    STAT_DIS_XHIGH   = 5'd14,
    STAT_TMAX        = 5'd15,
    STAT_TMIN        = 5'd16,
    STAT_VCMAX       = 5'd17,
    STAT_VCMIN       = 5'd18,
    STAT_VPMAX       = 5'd19,
    STAT_VPMIN       = 5'd20,
    STAT_BAL_TOTAL   = 5'd21,
    STAT_BAL_LONGEST = 5'd22,
    STAT_FAN_TOTAL   = 5'd23,
    STAT_FAN_LONGEST = 5'd24,
    STAT_CONTACTOR   = 5'd25
  } bul_stat_e;

  localparam logic [1:0] MODE_FROZEN  = 2'd0;
  localparam logic [1:0] MODE_INIT    = 2'd1;
  localparam logic [1:0] RELAY_CLOSED = 2'd1;
  localparam logic [1:0] RELAY_OPEN   = 2'd2;

  // SOC hysteresis points, tenths of percent
  localparam logic [9:0] SOC_FULL_ARM_LO   = 10'd970;
  localparam logic [9:0] SOC_FULL_ARM_HI   = 10'd989;
  localparam logic [9:0] SOC_FULL_LATCH    = 10'd990;
  localparam logic [9:0] SOC_FULL_RELEASE  = 10'd950;
  localparam logic [9:0] SOC_EMPTY_ARM_HI  = 10'd30;
  localparam logic [9:0] SOC_EMPTY_ARM_LO  = 10'd11;
  localparam logic [9:0] SOC_EMPTY_LATCH   = 10'd10;
  localparam logic [9:0] SOC_EMPTY_RELEASE = 10'd50;

  localparam logic signed [15:0] TMIN_RESET  = 16'sd1250;
  localparam logic [15:0]        VCMIN_RESET = 16'd5000;
  localparam logic [15:0]        VPMIN_RESET = 16'd20000;

  localparam logic signed [15:0] CHG_THR_RESET   = 16'sd10;
  localparam logic signed [15:0] DIS_THR_RESET   = -16'sd10;
  localparam logic signed [15:0] LOW_LIM_RESET   = -16'sd100;
  localparam logic signed [15:0] XLOW_LIM_RESET  = -16'sd150;
  localparam logic signed [15:0] HIGH_LIM_RESET  = 16'sd450;
  localparam logic signed [15:0] XHIGH_LIM_RESET = 16'sd500;
  localparam logic [7:0]         TPM_RESET       = 8'd60;
  localparam logic [7:0]         SETTLE_RESET    = 8'd10;

  typedef struct packed {
    logic signed [15:0] chg_thr;
    logic signed [15:0] dis_thr;
    logic signed [15:0] low_lim;
    logic signed [15:0] xlow_lim;
    logic signed [15:0] high_lim;
    logic signed [15:0] xhigh_lim;
    logic [7:0]         tpm;
    logic [7:0]         settle;
  } bul_cfg_t;

  typedef struct packed {
    logic signed [15:0] pack_current;
    logic signed [15:0] min_cell_temp;
    logic signed [15:0] max_cell_temp;
    logic [15:0]        max_cell_voltage;
    logic [15:0]        min_cell_voltage;
    logic [15:0]        pack_voltage;
    logic [9:0]         soc_permille;
    logic [1:0]         system_mode;
    logic [1:0]         aux_activity;
    logic [1:0]         relay_state;
  } bul_tick_t;

endpackage

// ===== hw/rtl/bul_if.sv =====
// Channel interfaces of the battery usage statistics logger: request,
// response and configuration write. No dependencies.
interface bul_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [4:0]         stat_index;
  logic signed [15:0] pack_current;
  logic signed [15:0] min_cell_temp;
  logic signed [15:0] max_cell_temp;
  logic [15:0]        max_cell_voltage;
  logic [15:0]        min_cell_voltage;
  logic [15:0]        pack_voltage;
  logic [9:0]         soc_permille;
  logic [1:0]         system_mode;
  logic [1:0]         aux_activity;
  logic [1:0]         relay_state;

  modport source (
    output valid, req_type, stat_index, pack_current, min_cell_temp, max_cell_temp,
           max_cell_voltage, min_cell_voltage, pack_voltage, soc_permille,
           system_mode, aux_activity, relay_state,
    input  ready
  );
  modport sink (
    input  valid, req_type, stat_index, pack_current, min_cell_temp, max_cell_temp,
           max_cell_voltage, min_cell_voltage, pack_voltage, soc_permille,
           system_mode, aux_activity, relay_state,
    output ready
  );
endinterface

interface bul_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] stat_value;
  logic        bad_index;

  modport source (output valid, stat_value, bad_index, input ready);
  modport sink (input valid, stat_value, bad_index, output ready);
endinterface

interface bul_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bul_stats.sv =====
// Statistics store and per-tick update logic of the usage logger.
// Depends on bul_pkg.
module bul_stats #(
  parameter int unsigned COUNTER_WIDTH = bul_pkg::BUL_COUNTER_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bul_pkg::bul_cfg_t  cfg_i,
  input  logic              tick_valid_i,
  input  bul_pkg::bul_tick_t tick_i,
  input  logic [4:0]        rd_index_i,
  output logic [31:0]       rd_value_o,
  output logic              rd_bad_o
);
  import bul_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;

  typedef struct packed {
    logic [7:0] sec;
    logic       due;
  } minute_t;

  // Advance a sub-minute tick counter; due when a minute completes.
  function automatic minute_t minute_step(logic [7:0] sec, logic [7:0] tpm);
    logic [8:0] nxt;
    minute_t    r;
    nxt = {1'b0, sec} + 9'd1;
    if (nxt >= {1'b0, tpm}) begin
      r.sec = 8'd0;
      r.due = 1'b1;
    end else begin
      r.sec = nxt[7:0];
      r.due = 1'b0;
    end
    return r;
  endfunction

  // Direction 0 is charging, 1 discharging.
  // Sub counters: 0 total, 1 low, 2 extreme low, 3 high, 4 extreme high.
  // Band minutes: 0 low, 1 high, 2 extreme low, 3 extreme high.
  logic [CW-1:0] op_total_q, op_total_d, op_longest_q, op_longest_d;
  logic [7:0]    op_sub_q, op_sub_d;
  logic [CW-1:0] dir_total_q [2], dir_total_d [2];
  logic [7:0]    dir_sub_q [2][5], dir_sub_d [2][5];
  logic [15:0]   dir_band_q [2][4], dir_band_d [2][4];
  logic [15:0]   full_cnt_q, full_cnt_d, empty_cnt_q, empty_cnt_d;
  logic          full_latch_q, full_latch_d, full_arm_q, full_arm_d;
  logic          empty_latch_q, empty_latch_d, empty_arm_q, empty_arm_d;
  logic          cont_on_q, cont_on_d;
  logic [15:0]   cont_cnt_q, cont_cnt_d;
  logic [7:0]    settle_q, settle_d;
  logic signed [15:0] tmax_q, tmax_d, tmin_q, tmin_d;
  logic [15:0]   vcmax_q, vcmax_d, vcmin_q, vcmin_d, vpmax_q, vpmax_d, vpmin_q, vpmin_d;
  // Index 0 balancing, 1 fan.
  logic [CW-1:0] aux_total_q [2], aux_total_d [2];
  logic [15:0]   aux_longest_q [2], aux_longest_d [2];
  logic [15:0]   aux_run_q [2], aux_run_d [2];
  logic [7:0]    aux_sub_q [2], aux_sub_d [2];

  always_comb begin
    minute_t     m;
    logic        dir_on;
    logic        arm;
    logic [15:0] run_nxt;
    op_total_d    = op_total_q;
    op_longest_d  = op_longest_q;
    op_sub_d      = op_sub_q;
    dir_total_d   = dir_total_q;
    dir_sub_d     = dir_sub_q;
    dir_band_d    = dir_band_q;
    full_cnt_d    = full_cnt_q;
    empty_cnt_d   = empty_cnt_q;
    full_latch_d  = full_latch_q;
    full_arm_d    = full_arm_q;
    empty_latch_d = empty_latch_q;
    empty_arm_d   = empty_arm_q;
    cont_on_d     = cont_on_q;
    cont_cnt_d    = cont_cnt_q;
    settle_d      = settle_q;
    tmax_d        = tmax_q;
    tmin_d        = tmin_q;
    vcmax_d       = vcmax_q;
    vcmin_d       = vcmin_q;
    vpmax_d       = vpmax_q;
    vpmin_d       = vpmin_q;
    aux_total_d   = aux_total_q;
    aux_longest_d = aux_longest_q;
    aux_run_d     = aux_run_q;
    aux_sub_d     = aux_sub_q;
    m             = '0;
    dir_on        = 1'b0;
    arm           = 1'b0;
    run_nxt       = '0;

    if (tick_valid_i && tick_i.system_mode != MODE_FROZEN) begin
      // Direction minutes and temperature bands
      for (int d = 0; d < 2; d++) begin
        if (d == 0) begin
          dir_on = $signed(tick_i.pack_current) >= $signed(cfg_i.chg_thr);
        end else begin
          dir_on = $signed(tick_i.pack_current) <= $signed(cfg_i.dis_thr);
        end
        if (dir_on) begin
          m = minute_step(dir_sub_q[d][0], cfg_i.tpm);
          dir_sub_d[d][0] = m.sec;
          if (m.due) dir_total_d[d] = dir_total_q[d] + CW'(1);
          if ($signed(tick_i.min_cell_temp) < $signed(cfg_i.low_lim)) begin
            m = minute_step(dir_sub_q[d][1], cfg_i.tpm);
            dir_sub_d[d][1] = m.sec;
            if (m.due) dir_band_d[d][0] = dir_band_q[d][0] + 16'd1;
            if ($signed(tick_i.min_cell_temp) < $signed(cfg_i.xlow_lim)) begin
              m = minute_step(dir_sub_q[d][2], cfg_i.tpm);
              dir_sub_d[d][2] = m.sec;
              if (m.due) dir_band_d[d][2] = dir_band_q[d][2] + 16'd1;
            end
          end
          if ($signed(tick_i.max_cell_temp) > $signed(cfg_i.high_lim)) begin
            m = minute_step(dir_sub_q[d][3], cfg_i.tpm);
            dir_sub_d[d][3] = m.sec;
            if (m.due) dir_band_d[d][1] = dir_band_q[d][1] + 16'd1;
            if ($signed(tick_i.max_cell_temp) > $signed(cfg_i.xhigh_lim)) begin
              m = minute_step(dir_sub_q[d][4], cfg_i.tpm);
              dir_sub_d[d][4] = m.sec;
              if (m.due) dir_band_d[d][3] = dir_band_q[d][3] + 16'd1;
            end
          end
        end
      end

      // Full-charge event with arm and latch hysteresis
      if (!full_latch_q) begin
        arm = full_arm_q || (tick_i.soc_permille >= SOC_FULL_ARM_LO &&
                             tick_i.soc_permille <= SOC_FULL_ARM_HI);
        if (tick_i.soc_permille >= SOC_FULL_LATCH && arm) begin
          full_latch_d = 1'b1;
          full_arm_d   = 1'b0;
          full_cnt_d   = full_cnt_q + 16'd1;
        end else begin
          full_arm_d = arm;
        end
      end else if (tick_i.soc_permille <= SOC_FULL_RELEASE) begin
        full_latch_d = 1'b0;
      end

      // Empty event, not counted during init
      if (!empty_latch_q) begin
        arm = empty_arm_q || (tick_i.soc_permille <= SOC_EMPTY_ARM_HI &&
                              tick_i.soc_permille >= SOC_EMPTY_ARM_LO);
        if (tick_i.system_mode != MODE_INIT && tick_i.soc_permille <= SOC_EMPTY_LATCH &&
            arm) begin
          empty_latch_d = 1'b1;
          empty_arm_d   = 1'b0;
          empty_cnt_d   = empty_cnt_q + 16'd1;
        end else begin
          empty_arm_d = arm;
        end
      end else if (tick_i.soc_permille >= SOC_EMPTY_RELEASE) begin
        empty_latch_d = 1'b0;
      end

      // Extremes after the settle delay
      if (settle_q >= cfg_i.settle) begin
        if ($signed(tick_i.max_cell_temp) > tmax_q) tmax_d = tick_i.max_cell_temp;
        if ($signed(tick_i.min_cell_temp) < tmin_q) tmin_d = tick_i.min_cell_temp;
        if (tick_i.max_cell_voltage > vcmax_q) vcmax_d = tick_i.max_cell_voltage;
        if (tick_i.min_cell_voltage < vcmin_q) vcmin_d = tick_i.min_cell_voltage;
        if (tick_i.pack_voltage > vpmax_q) vpmax_d = tick_i.pack_voltage;
        if (tick_i.pack_voltage < vpmin_q) vpmin_d = tick_i.pack_voltage;
      end else begin
        settle_d = settle_q + 8'd1;
      end

      // Balancing and fan minutes with longest runs
      for (int a = 0; a < 2; a++) begin
        if (!tick_i.aux_activity[a]) begin
          aux_sub_d[a] = 8'd0;
          aux_run_d[a] = 16'd0;
        end else begin
          m = minute_step(aux_sub_q[a], cfg_i.tpm);
          aux_sub_d[a] = m.sec;
          if (m.due) begin
            run_nxt        = aux_run_q[a] + 16'd1;
            aux_total_d[a] = aux_total_q[a] + CW'(1);
            aux_run_d[a]   = run_nxt;
            if (run_nxt > aux_longest_q[a]) aux_longest_d[a] = run_nxt;
          end
        end
      end

      // Contactor closures
      if (!cont_on_q) begin
        if (tick_i.relay_state == RELAY_CLOSED) begin
          cont_on_d  = 1'b1;
          cont_cnt_d = cont_cnt_q + 16'd1;
        end
      end else if (tick_i.relay_state == RELAY_OPEN) begin
        cont_on_d = 1'b0;
      end

      // Operating minutes; the total and the current run move together
      m = minute_step(op_sub_q, cfg_i.tpm);
      op_sub_d = m.sec;
      if (m.due) begin
        op_total_d = op_total_q + CW'(1);
        if (op_total_d >= op_longest_q) op_longest_d = op_total_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_total_q    <= '0;
      op_longest_q  <= '0;
      op_sub_q      <= '0;
      for (int d = 0; d < 2; d++) begin
        dir_total_q[d] <= '0;
        for (int s = 0; s < 5; s++) dir_sub_q[d][s] <= '0;
        for (int b = 0; b < 4; b++) dir_band_q[d][b] <= '0;
        aux_total_q[d]   <= '0;
        aux_longest_q[d] <= '0;
        aux_run_q[d]     <= '0;
        aux_sub_q[d]     <= '0;
      end
      full_cnt_q    <= '0;
      empty_cnt_q   <= '0;
      full_latch_q  <= 1'b0;
      full_arm_q    <= 1'b0;
      empty_latch_q <= 1'b0;
      empty_arm_q   <= 1'b0;
      cont_on_q     <= 1'b0;
      cont_cnt_q    <= '0;
      settle_q      <= '0;
      tmax_q        <= '0;
      tmin_q        <= TMIN_RESET;
      vcmax_q       <= '0;
      vcmin_q       <= VCMIN_RESET;
      vpmax_q       <= '0;
      vpmin_q       <= VPMIN_RESET;
    end else begin
      op_total_q    <= op_total_d;
      op_longest_q  <= op_longest_d;
      op_sub_q      <= op_sub_d;
      dir_total_q   <= dir_total_d;
      dir_sub_q     <= dir_sub_d;
      dir_band_q    <= dir_band_d;
      aux_total_q   <= aux_total_d;
      aux_longest_q <= aux_longest_d;
      aux_run_q     <= aux_run_d;
      aux_sub_q     <= aux_sub_d;
      full_cnt_q    <= full_cnt_d;
      empty_cnt_q   <= empty_cnt_d;
      full_latch_q  <= full_latch_d;
      full_arm_q    <= full_arm_d;
      empty_latch_q <= empty_latch_d;
      empty_arm_q   <= empty_arm_d;
      cont_on_q     <= cont_on_d;
      cont_cnt_q    <= cont_cnt_d;
      settle_q      <= settle_d;
      tmax_q        <= tmax_d;
      tmin_q        <= tmin_d;
      vcmax_q       <= vcmax_d;
      vcmin_q       <= vcmin_d;
      vpmax_q       <= vpmax_d;
      vpmin_q       <= vpmin_d;
    end
  end

  // Read select
  always_comb begin
    rd_bad_o   = 1'b0;
    rd_value_o = '0;
    case (bul_stat_e'(rd_index_i))
      STAT_OP_TOTAL:    rd_value_o = BUL_STAT_WIDTH'(op_total_q);
      STAT_OP_LAST:     rd_value_o = BUL_STAT_WIDTH'(op_total_q);
      STAT_OP_LONGEST:  rd_value_o = BUL_STAT_WIDTH'(op_longest_q);
      STAT_CHG_TOTAL:   rd_value_o = BUL_STAT_WIDTH'(dir_total_q[0]);
      STAT_FULL_COUNT:  rd_value_o = {16'd0, full_cnt_q};
      STAT_CHG_LOW:     rd_value_o = {16'd0, dir_band_q[0][0]};
      STAT_CHG_HIGH:    rd_value_o = {16'd0, dir_band_q[0][1]};
      STAT_CHG_XLOW:    rd_value_o = {16'd0, dir_band_q[0][2]};
      STAT_CHG_XHIGH:   rd_value_o = {16'd0, dir_band_q[0][3]};
      STAT_DIS_TOTAL:   rd_value_o = BUL_STAT_WIDTH'(dir_total_q[1]);
      STAT_EMPTY_COUNT: rd_value_o = {16'd0, empty_cnt_q};
      STAT_DIS_LOW:     rd_value_o = {16'd0, dir_band_q[1][0]};
      STAT_DIS_HIGH:    rd_value_o = {16'd0, dir_band_q[1][1]};
      STAT_DIS_XLOW:    rd_value_o = {16'd0, dir_band_q[1][2]};
      STAT_DIS_XHIGH:   rd_value_o = {16'd0, dir_band_q[1][3]};
      STAT_TMAX:        rd_value_o = {{16{tmax_q[15]}}, tmax_q};
      STAT_TMIN:        rd_value_o = {{16{tmin_q[15]}}, tmin_q};
      STAT_VCMAX:       rd_value_o = {16'd0, vcmax_q};
      STAT_VCMIN:       rd_value_o = {16'd0, vcmin_q};
      STAT_VPMAX:       rd_value_o = {16'd0, vpmax_q};
      STAT_VPMIN:       rd_value_o = {16'd0, vpmin_q};
      STAT_BAL_TOTAL:   rd_value_o = BUL_STAT_WIDTH'(aux_total_q[0]);
      STAT_BAL_LONGEST: rd_value_o = {16'd0, aux_longest_q[0]};
      STAT_FAN_TOTAL:   rd_value_o = BUL_STAT_WIDTH'(aux_total_q[1]);
      STAT_FAN_LONGEST: rd_value_o = {16'd0, aux_longest_q[1]};
      STAT_CONTACTOR:   rd_value_o = {16'd0, cont_cnt_q};
      default:          rd_bad_o   = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/battery_usage_statistics_logger_top.sv =====
// Top level of the battery usage statistics logger: channel handshakes,
// configuration registers, input and result registers around bul_stats.
// Depends on bul_pkg, bul_if and bul_stats.
//
// Usage:
//   req_i  carries one transaction per item: a tick (req_type 0) with one
//          second of pack telemetry, or a read (req_type 1) of statistic
//          stat_index. Ticks return nothing; reads return one transaction.
//   rsp_o  returns stat_value and bad_index for each read, in order.
//   cfg_i  writes threshold and timing registers by index; always ready.
//          Write only while no item is in flight.
// Order: a read passes the input register, then the result register once it
// is free, and sees every tick accepted before it. Throughput: one item per
// cycle unless a read waits on rsp_o; the statistics update is a single pass
// of compares and increments between the input register and the state.
// Reset: statistics clear (minimum temperature and voltages to their high
// start values), configuration returns to defaults, both channels empty.
// Stall: while rsp_o holds an untaken result, ticks keep flowing; a read
// waits in the input register and req_i drops ready until rsp_o drains.
module battery_usage_statistics_logger_top #(
  parameter int unsigned COUNTER_WIDTH = bul_pkg::BUL_COUNTER_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bul_req_if.sink   req_i,
  bul_rsp_if.source rsp_o,
  bul_cfg_if.sink   cfg_i
);
  import bul_pkg::*;

  bul_cfg_t  cfg_q, cfg_d;

  logic      pipe_valid_q, pipe_valid_d;
  logic      pipe_type_q;
  logic [4:0] pipe_index_q;
  bul_tick_t pipe_tick_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q;
  logic        out_bad_q;

  logic        req_acc;
  logic        out_free;
  logic        pipe_fire;
  logic        pipe_is_read;
  logic [31:0] rd_value;
  logic        rd_bad;

  // Configuration writes: the port never stalls
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (bul_cfg_reg_e'(cfg_i.index))
        REG_CHG_THR:   cfg_d.chg_thr   = cfg_i.data;
        REG_DIS_THR:   cfg_d.dis_thr   = cfg_i.data;
        REG_LOW_LIM:   cfg_d.low_lim   = cfg_i.data;
        REG_XLOW_LIM:  cfg_d.xlow_lim  = cfg_i.data;
        REG_HIGH_LIM:  cfg_d.high_lim  = cfg_i.data;
        REG_XHIGH_LIM: cfg_d.xhigh_lim = cfg_i.data;
        REG_TPM:       cfg_d.tpm       = cfg_i.data[7:0];
        REG_SETTLE:    cfg_d.settle    = cfg_i.data[7:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chg_thr   <= CHG_THR_RESET;
      cfg_q.dis_thr   <= DIS_THR_RESET;
      cfg_q.low_lim   <= LOW_LIM_RESET;
      cfg_q.xlow_lim  <= XLOW_LIM_RESET;
      cfg_q.high_lim  <= HIGH_LIM_RESET;
      cfg_q.xhigh_lim <= XHIGH_LIM_RESET;
      cfg_q.tpm       <= TPM_RESET;
      cfg_q.settle    <= SETTLE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Handshake: a tick always leaves the input register; a read leaves only
  // when the result register is free or being emptied this cycle.
  assign pipe_is_read = (pipe_type_q == REQ_READ);
  assign out_free     = !out_valid_q || rsp_o.ready;
  assign pipe_fire    = pipe_valid_q && (!pipe_is_read || out_free);
  assign req_i.ready  = !pipe_valid_q || pipe_fire;
  assign req_acc      = req_i.valid && req_i.ready;

  always_comb begin
    pipe_valid_d = pipe_valid_q;
    if (req_acc) begin
      pipe_valid_d = 1'b1;
    end else if (pipe_fire) begin
      pipe_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pipe_fire && pipe_is_read) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pipe_valid_q <= pipe_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Input register payload: load on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      pipe_type_q                   <= req_i.req_type;
      pipe_index_q                  <= req_i.stat_index;
      pipe_tick_q.pack_current      <= req_i.pack_current;
      pipe_tick_q.min_cell_temp     <= req_i.min_cell_temp;
      pipe_tick_q.max_cell_temp     <= req_i.max_cell_temp;
      pipe_tick_q.max_cell_voltage  <= req_i.max_cell_voltage;
      pipe_tick_q.min_cell_voltage  <= req_i.min_cell_voltage;
      pipe_tick_q.pack_voltage      <= req_i.pack_voltage;
      pipe_tick_q.soc_permille      <= req_i.soc_permille;
      pipe_tick_q.system_mode       <= req_i.system_mode;
      pipe_tick_q.aux_activity      <= req_i.aux_activity;
      pipe_tick_q.relay_state       <= req_i.relay_state;
    end
  end

  // Result register payload: hold until the read leaves the input register
  always_ff @(posedge clk_i) begin
    if (pipe_fire && pipe_is_read) begin
      out_value_q <= rd_value;
      out_bad_q   <= rd_bad;
    end
  end

  bul_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tick_valid_i (pipe_fire && !pipe_is_read),
    .tick_i       (pipe_tick_q),
    .rd_index_i   (pipe_index_q),
    .rd_value_o   (rd_value),
    .rd_bad_o     (rd_bad)
  );

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.stat_value = out_value_q;
  assign rsp_o.bad_index  = out_bad_q;

endmodule

// ===== hw/rtl/bul_checker.sv =====
// Port-level checks for the battery usage statistics logger, bound to the
// top level. Depends on battery_usage_statistics_logger_top.
module bul_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_value_i,
  input logic        rsp_bad_i,
  input logic        cfg_ready_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_value_i) && $stable(rsp_bad_i))
    else $error("stalled result changed");

  // An out-of-range read carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_bad_i |-> rsp_value_i == 32'd0)
    else $error("bad index with non-zero value");

  // Configuration writes never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port stalled");

endmodule

bind battery_usage_statistics_logger_top bul_checker u_bul_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_value_i (rsp_o.stat_value),
  .rsp_bad_i   (rsp_o.bad_index),
  .cfg_ready_i (cfg_i.ready)
);

// ===== dv/bul_usage_checker.sv =====
`timescale 1ns / 100ps
// Checker for the battery usage statistics logger: watches the request,
// response and configuration channels, keeps its own copy of the statistics
// and compares every read result. Depends on bul_pkg and bul_if.
module bul_usage_checker
  import bul_pkg::*;
#(
  parameter int unsigned CNT_W = BUL_COUNTER_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  bul_req_if   req_i,
  bul_rsp_if   rsp_i,
  bul_cfg_if   cfg_i,
  output int   pending_reads_o,
  output int   mismatches_o
);

  localparam int STAT_COUNT = 26;
  localparam logic [31:0] WIDE_MASK =
    (CNT_W >= 32) ? 32'hFFFF_FFFF : ((32'h1 << CNT_W) - 32'h1);

  // slots of the sub-minute tick counters
  localparam int SEC_CHG = 0;
  localparam int SEC_DIS = 5;
  localparam int SEC_OP  = 10;
  localparam int SEC_BAL = 11;
  localparam int SEC_FAN = 12;

  typedef struct {
    logic [31:0] value;
    logic        bad;
  } stat_read_t;

  bul_cfg_t    cfg_now;
  logic [31:0] stat_regs [STAT_COUNT];
  logic [7:0]  sec_cnt [13];
  logic [15:0] aux_run [2];
  logic [31:0] run_min;
  logic [7:0]  settle_cnt;
  bit          full_latched, full_armed, empty_latched, empty_armed, contactor_on;
  stat_read_t  awaited_reads [$];
  int          mismatches = 0;

  function automatic bit minute_done(int slot);
    if ({1'b0, sec_cnt[slot]} + 9'd1 >= {1'b0, cfg_now.tpm}) begin
      sec_cnt[slot] = 8'd0;
      return 1'b1;
    end
    sec_cnt[slot] = sec_cnt[slot] + 8'd1;
    return 1'b0;
  endfunction

  function automatic void add_wide(bul_stat_e s);
    stat_regs[s] = (stat_regs[s] + 32'd1) & WIDE_MASK;
  endfunction

  function automatic void add_narrow(bul_stat_e s);
    stat_regs[s] = {16'h0, stat_regs[s][15:0] + 16'd1};
  endfunction

  // total minutes and temperature-band minutes for one current direction
  function automatic void count_direction(bit dis, logic signed [15:0] tmin,
                                          logic signed [15:0] tmax);
    int base;
    base = dis ? SEC_DIS : SEC_CHG;
    if (minute_done(base)) add_wide(dis ? STAT_DIS_TOTAL : STAT_CHG_TOTAL);
    if (tmin < $signed(cfg_now.low_lim)) begin
      if (minute_done(base + 1)) add_narrow(dis ? STAT_DIS_LOW : STAT_CHG_LOW);
      if (tmin < $signed(cfg_now.xlow_lim)) begin
        if (minute_done(base + 2)) add_narrow(dis ? STAT_DIS_XLOW : STAT_CHG_XLOW);
      end
    end
    if (tmax > $signed(cfg_now.high_lim)) begin
      if (minute_done(base + 3)) add_narrow(dis ? STAT_DIS_HIGH : STAT_CHG_HIGH);
      if (tmax > $signed(cfg_now.xhigh_lim)) begin
        if (minute_done(base + 4)) add_narrow(dis ? STAT_DIS_XHIGH : STAT_CHG_XHIGH);
      end
    end
  endfunction

  function automatic void track_aux(bit fan, bit on);
    int        slot;
    bul_stat_e total, longest;
    slot    = fan ? SEC_FAN : SEC_BAL;
    total   = fan ? STAT_FAN_TOTAL : STAT_BAL_TOTAL;
    longest = fan ? STAT_FAN_LONGEST : STAT_BAL_LONGEST;
    if (!on) begin
      sec_cnt[slot] = 8'd0;
      aux_run[fan]  = 16'd0;
      return;
    end
    if (minute_done(slot)) begin
      add_wide(total);
      aux_run[fan] = aux_run[fan] + 16'd1;
      if ({16'h0, aux_run[fan]} > stat_regs[longest]) stat_regs[longest] = {16'h0, aux_run[fan]};
    end
  endfunction

  function automatic void update_statistics(bul_tick_t t);
    logic signed [15:0] cur, tmin, tmax;
    logic [9:0]         soc;
    if (t.system_mode == MODE_FROZEN) return;
    cur  = t.pack_current;
    tmin = t.min_cell_temp;
    tmax = t.max_cell_temp;
    soc  = t.soc_permille;

    if (cur >= $signed(cfg_now.chg_thr)) count_direction(1'b0, tmin, tmax);

    if (!full_latched) begin
      if (soc >= SOC_FULL_ARM_LO && soc <= SOC_FULL_ARM_HI) full_armed = 1'b1;
      if (soc >= SOC_FULL_LATCH && full_armed) begin
        full_latched = 1'b1;
        full_armed   = 1'b0;
        add_narrow(STAT_FULL_COUNT);
      end
    end else if (soc <= SOC_FULL_RELEASE) begin
      full_latched = 1'b0;
    end

    if (cur <= $signed(cfg_now.dis_thr)) count_direction(1'b1, tmin, tmax);

    if (!empty_latched) begin
      if (soc <= SOC_EMPTY_ARM_HI && soc >= SOC_EMPTY_ARM_LO) empty_armed = 1'b1;
      if (t.system_mode != MODE_INIT && soc <= SOC_EMPTY_LATCH && empty_armed) begin
        empty_latched = 1'b1;
        empty_armed   = 1'b0;
        add_narrow(STAT_EMPTY_COUNT);
      end
    end else if (soc >= SOC_EMPTY_RELEASE) begin
      empty_latched = 1'b0;
    end

    if (settle_cnt >= cfg_now.settle) begin
      if (tmax > $signed(stat_regs[STAT_TMAX][15:0]))
        stat_regs[STAT_TMAX] = {{16{tmax[15]}}, tmax};
      if (tmin < $signed(stat_regs[STAT_TMIN][15:0]))
        stat_regs[STAT_TMIN] = {{16{tmin[15]}}, tmin};
      if ({16'h0, t.max_cell_voltage} > stat_regs[STAT_VCMAX])
        stat_regs[STAT_VCMAX] = {16'h0, t.max_cell_voltage};
      if ({16'h0, t.min_cell_voltage} < stat_regs[STAT_VCMIN])
        stat_regs[STAT_VCMIN] = {16'h0, t.min_cell_voltage};
      if ({16'h0, t.pack_voltage} > stat_regs[STAT_VPMAX])
        stat_regs[STAT_VPMAX] = {16'h0, t.pack_voltage};
      if ({16'h0, t.pack_voltage} < stat_regs[STAT_VPMIN])
        stat_regs[STAT_VPMIN] = {16'h0, t.pack_voltage};
    end else begin
      settle_cnt = settle_cnt + 8'd1;
    end

    track_aux(1'b0, t.aux_activity[0]);
    track_aux(1'b1, t.aux_activity[1]);

    if (!contactor_on) begin
      if (t.relay_state == RELAY_CLOSED) begin
        contactor_on = 1'b1;
        add_narrow(STAT_CONTACTOR);
      end
    end else if (t.relay_state == RELAY_OPEN) begin
      contactor_on = 1'b0;
    end

    if (minute_done(SEC_OP)) begin
      run_min = (run_min + 32'd1) & WIDE_MASK;
      add_wide(STAT_OP_TOTAL);
      stat_regs[STAT_OP_LAST] = run_min;
      if (run_min >= stat_regs[STAT_OP_LONGEST]) stat_regs[STAT_OP_LONGEST] = run_min;
    end
  endfunction

  always @(posedge clk_i) begin
    stat_read_t want, due;
    bul_tick_t  tick;
    if (!rst_ni) begin
      foreach (stat_regs[i]) stat_regs[i] = 32'h0;
      stat_regs[STAT_TMIN]  = {{16{TMIN_RESET[15]}}, TMIN_RESET};
      stat_regs[STAT_VCMIN] = {16'h0, VCMIN_RESET};
      stat_regs[STAT_VPMIN] = {16'h0, VPMIN_RESET};
      foreach (sec_cnt[i]) sec_cnt[i] = 8'd0;
      aux_run[0]    = 16'd0;
      aux_run[1]    = 16'd0;
      run_min       = 32'd0;
      settle_cnt    = 8'd0;
      full_latched  = 1'b0;
      full_armed    = 1'b0;
      empty_latched = 1'b0;
      empty_armed   = 1'b0;
      contactor_on  = 1'b0;
      cfg_now = {CHG_THR_RESET, DIS_THR_RESET, LOW_LIM_RESET, XLOW_LIM_RESET,
                 HIGH_LIM_RESET, XHIGH_LIM_RESET, TPM_RESET, SETTLE_RESET};
      awaited_reads.delete();
    end else begin
      // results first: a read accepted now cannot answer at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_reads.size() == 0) begin
          $error("unexpected result: stat_value %h bad_index %b",
                 rsp_i.stat_value, rsp_i.bad_index);
          mismatches++;
        end else begin
          want = awaited_reads.pop_front();
          if (rsp_i.stat_value !== want.value) begin
            $error("stat_value: expected %h, got %h", want.value, rsp_i.stat_value);
            mismatches++;
          end
          if (rsp_i.bad_index !== want.bad) begin
            $error("bad_index: expected %b, got %b", want.bad, rsp_i.bad_index);
            mismatches++;
          end
        end
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (bul_cfg_reg_e'(cfg_i.index))
          REG_CHG_THR:   cfg_now.chg_thr   = cfg_i.data;
          REG_DIS_THR:   cfg_now.dis_thr   = cfg_i.data;
          REG_LOW_LIM:   cfg_now.low_lim   = cfg_i.data;
          REG_XLOW_LIM:  cfg_now.xlow_lim  = cfg_i.data;
          REG_HIGH_LIM:  cfg_now.high_lim  = cfg_i.data;
          REG_XHIGH_LIM: cfg_now.xhigh_lim = cfg_i.data;
          REG_TPM:       cfg_now.tpm       = cfg_i.data[7:0];
          REG_SETTLE:    cfg_now.settle    = cfg_i.data[7:0];
          default: ;
        endcase
      end

      if (req_i.valid && req_i.ready) begin
        if (req_i.req_type == REQ_READ) begin
          if (req_i.stat_index < STAT_COUNT) due = '{stat_regs[req_i.stat_index], 1'b0};
          else due = '{32'h0, 1'b1};
          awaited_reads.push_back(due);
        end else begin
          tick = '{req_i.pack_current, req_i.min_cell_temp, req_i.max_cell_temp,
                   req_i.max_cell_voltage, req_i.min_cell_voltage, req_i.pack_voltage,
                   req_i.soc_permille, req_i.system_mode, req_i.aux_activity,
                   req_i.relay_state};
          update_statistics(tick);
        end
      end
    end
    pending_reads_o <= awaited_reads.size();
    mismatches_o    <= mismatches;
  end

endmodule

// ===== dv/tb_battery_usage_statistics_logger_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the battery usage statistics logger: clock, reset,
// stimulus, configuration phases and verdict. Depends on bul_pkg, bul_if,
// bul_usage_checker and the logger RTL.
module tb_battery_usage_statistics_logger_top;
  import bul_pkg::*;

  // operating and relay codes the package does not name
  localparam logic [1:0] MODE_NORMAL = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam logic [1:0] RELAY_OTHER = 2'd0;
  localparam logic [1:0] RELAY_SPARE = 2'd3;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int DRAIN_CYCLES    = 6;     // margin for the pipeline to empty
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transaction on any channel

  typedef struct packed {
    bul_req_type_e kind;
    logic [4:0]    index;
    bul_tick_t     tick;
  } req_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bul_req_if req_ch ();
  bul_rsp_if rsp_ch ();
  bul_cfg_if cfg_ch ();

  int pending_reads;
  int mismatches;

  battery_usage_statistics_logger_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  bul_usage_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_ch),
    .rsp_i           (rsp_ch),
    .cfg_i           (cfg_ch),
    .pending_reads_o (pending_reads),
    .mismatches_o    (mismatches)
  );

  always #5 clk_i = ~clk_i;

  // Idling percentages of the current phase.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  // Aux and relay states persist over several ticks so runs build up.
  logic [1:0] aux_hold   = 2'd0;
  logic [1:0] relay_hold = RELAY_OTHER;

  int ticks_sent = 0;
  int frozen_sent = 0;
  int reads_sent = 0;

  // Receiver: stall on a per-cycle coin flip at the phase's rate.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: end the run if no channel moves a transaction for too long.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles, %0d reads still outstanding",
             WATCHDOG_LIMIT, pending_reads);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random tick or read. Telemetry leans towards the SOC hysteresis points
  // and the default band limits so that the event and band logic is reached.
  function automatic req_item_t random_item();
    req_item_t it;
    int        pick;
    it.kind  = ($urandom_range(99) < 30) ? REQ_READ : REQ_TICK;
    it.index = 5'($urandom_range(31));

    it.tick.pack_current = ($urandom_range(2) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(100)) - 16'd50;
    it.tick.min_cell_temp = $urandom_range(1) ? 16'($urandom)
                                              : 16'($urandom_range(700)) - 16'd400;
    it.tick.max_cell_temp = $urandom_range(1) ? 16'($urandom)
                                              : 16'($urandom_range(900)) - 16'd200;
    it.tick.max_cell_voltage = $urandom_range(1) ? 16'($urandom)
                                                 : 16'($urandom_range(4400, 3000));
    it.tick.min_cell_voltage = $urandom_range(1) ? 16'($urandom)
                                                 : 16'($urandom_range(4200, 2500));
    it.tick.pack_voltage = $urandom_range(1) ? 16'($urandom)
                                             : 16'($urandom_range(22000, 15000));

    case ($urandom_range(7))
      0:       it.tick.soc_permille = 10'($urandom_range(15));
      1:       it.tick.soc_permille = 10'($urandom_range(35, 8));
      2:       it.tick.soc_permille = 10'($urandom_range(55, 45));
      3:       it.tick.soc_permille = 10'($urandom_range(975, 940));
      4:       it.tick.soc_permille = 10'($urandom_range(995, 965));
      5:       it.tick.soc_permille = 10'($urandom_range(1023, 985));
      default: it.tick.soc_permille = 10'($urandom_range(1023));
    endcase

    pick = $urandom_range(19);
    if (pick == 0)      it.tick.system_mode = MODE_FROZEN;
    else if (pick < 3)  it.tick.system_mode = MODE_INIT;
    else if (pick == 3) it.tick.system_mode = MODE_SPARE;
    else                it.tick.system_mode = MODE_NORMAL;

    if ($urandom_range(9) == 0) aux_hold = 2'($urandom_range(3));
    if ($urandom_range(4) == 0) relay_hold = 2'($urandom_range(3));
    it.tick.aux_activity = aux_hold;
    it.tick.relay_state  = relay_hold;
    return it;
  endfunction

  function automatic req_item_t read_of(logic [4:0] idx);
    req_item_t it;
    it       = random_item();
    it.kind  = REQ_READ;
    it.index = idx;
    return it;
  endfunction

  function automatic req_item_t tick_of(logic [1:0] mode, logic [15:0] cur,
                                        logic [15:0] tmin, logic [15:0] tmax,
                                        logic [15:0] vhi, logic [15:0] vlo,
                                        logic [15:0] vpack, logic [9:0] soc,
                                        logic [1:0] aux, logic [1:0] relay);
    req_item_t it;
    it.kind  = REQ_TICK;
    it.index = 5'($urandom_range(31));
    it.tick  = '{cur, tmin, tmax, vhi, vlo, vpack, soc, mode, aux, relay};
    return it;
  endfunction

  // Present one item, after random idle cycles, and hold it until taken.
  // Valid stays high on return so back-to-back items need no gap.
  task automatic send_item(input req_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid            <= 1'b1;
    req_ch.req_type         <= it.kind;
    req_ch.stat_index       <= it.index;
    req_ch.pack_current     <= it.tick.pack_current;
    req_ch.min_cell_temp    <= it.tick.min_cell_temp;
    req_ch.max_cell_temp    <= it.tick.max_cell_temp;
    req_ch.max_cell_voltage <= it.tick.max_cell_voltage;
    req_ch.min_cell_voltage <= it.tick.min_cell_voltage;
    req_ch.pack_voltage     <= it.tick.pack_voltage;
    req_ch.soc_permille     <= it.tick.soc_permille;
    req_ch.system_mode      <= it.tick.system_mode;
    req_ch.aux_activity     <= it.tick.aux_activity;
    req_ch.relay_state      <= it.tick.relay_state;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    if (it.kind == REQ_READ) reads_sent++;
    else if (it.tick.system_mode == MODE_FROZEN) frozen_sent++;
    else ticks_sent++;
  endtask

  // Drop valid, wait for every read to come back, then let the pipeline
  // empty out behind the last tick.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_reads != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input bul_cfg_reg_e idx, input logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  // Write every register; the unused upper byte of the 8-bit ones gets noise.
  task automatic load_config(input bul_cfg_t c);
    write_reg(REG_CHG_THR, c.chg_thr);
    write_reg(REG_DIS_THR, c.dis_thr);
    write_reg(REG_LOW_LIM, c.low_lim);
    write_reg(REG_XLOW_LIM, c.xlow_lim);
    write_reg(REG_HIGH_LIM, c.high_lim);
    write_reg(REG_XHIGH_LIM, c.xhigh_lim);
    write_reg(REG_TPM, {8'($urandom_range(255)), c.tpm});
    write_reg(REG_SETTLE, {8'($urandom_range(255)), c.settle});
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    bul_cfg_t cfg;
    rst_ni                  = 1'b0;
    req_ch.valid            = 1'b0;
    req_ch.req_type         = REQ_TICK;
    req_ch.stat_index       = '0;
    req_ch.pack_current     = '0;
    req_ch.min_cell_temp    = '0;
    req_ch.max_cell_temp    = '0;
    req_ch.max_cell_voltage = '0;
    req_ch.min_cell_voltage = '0;
    req_ch.pack_voltage     = '0;
    req_ch.soc_permille     = '0;
    req_ch.system_mode      = MODE_FROZEN;
    req_ch.aux_activity     = '0;
    req_ch.relay_state      = RELAY_OTHER;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = REG_CHG_THR;
    cfg_ch.data             = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset values and bad indices first, then the frozen,
    // init and spare modes, the SOC event edges, threshold and band
    // boundaries and field extremes. One tick per minute and no settle
    // delay make every effect visible at once.
    load_config({CHG_THR_RESET, DIS_THR_RESET, LOW_LIM_RESET, XLOW_LIM_RESET,
                 HIGH_LIM_RESET, XHIGH_LIM_RESET, 8'd1, 8'd0});
    send_item(read_of(STAT_TMIN));
    send_item(read_of(STAT_VPMIN));
    send_item(read_of(5'd31));
    send_item(read_of(5'd26));
    // frozen: nothing at all may change, even with everything at full scale
    send_item(tick_of(MODE_FROZEN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                      16'hFFFF, 10'd1000, 2'd3, RELAY_CLOSED));
    send_item(read_of(STAT_CONTACTOR));
    // init mode arms the empty event but may not count it
    send_item(tick_of(MODE_INIT, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                      16'hFFFF, 10'd20, 2'd3, RELAY_CLOSED));
    send_item(tick_of(MODE_INIT, 16'h8000, 16'h0000, 16'h0000, 16'd3700, 16'd3600,
                      16'd15000, 10'd5, 2'd3, RELAY_OTHER));
    // spare mode acts as normal, so the armed empty event counts here
    send_item(tick_of(MODE_SPARE, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                      16'h0000, 10'd10, 2'd1, RELAY_SPARE));
    send_item(tick_of(MODE_NORMAL, 16'h0000, 16'd0, 16'd0, 16'd3700, 16'd3600,
                      16'd15000, 10'd975, 2'd2, RELAY_OPEN));
    // SOC above the nominal range latches the full event
    send_item(tick_of(MODE_NORMAL, 16'd10, 16'd0, 16'd0, 16'd3700, 16'd3600,
                      16'd15000, 10'd1023, 2'd0, RELAY_CLOSED));
    send_item(tick_of(MODE_NORMAL, -16'sd10, -16'sd151, 16'sd501, 16'd3700, 16'd3600,
                      16'd15000, 10'd950, 2'd2, RELAY_CLOSED));
    send_item(tick_of(MODE_NORMAL, 16'd11, -16'sd100, 16'sd450, 16'd3700, 16'd3600,
                      16'd15000, 10'd60, 2'd2, RELAY_OTHER));
    send_item(read_of(STAT_FULL_COUNT));
    send_item(read_of(STAT_EMPTY_COUNT));
    send_item(read_of(STAT_TMAX));
    send_item(read_of(STAT_TMIN));
    send_item(read_of(STAT_VCMAX));
    send_item(read_of(STAT_VPMIN));
    send_item(read_of(STAT_CHG_XLOW));
    send_item(read_of(STAT_DIS_XHIGH));
    send_item(read_of(STAT_FAN_LONGEST));
    send_item(read_of(STAT_CONTACTOR));
    send_item(read_of(STAT_OP_LONGEST));

    // Random part: each phase takes a fresh register setting and one of the
    // idling patterns, after the block has gone idle.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
        default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
      endcase
      case (phase)
        0: cfg = {CHG_THR_RESET, DIS_THR_RESET, LOW_LIM_RESET, XLOW_LIM_RESET,
                  HIGH_LIM_RESET, XHIGH_LIM_RESET, TPM_RESET, SETTLE_RESET};
        // crossed thresholds, every band hit, zero ticks per minute
        1: cfg = {16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0000,
                  16'sh8000, 16'sh0000, 8'd0, 8'd0};
        // the opposite corner: longest minute and longest settle delay
        2: cfg = {16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh7FFF, 16'sh7FFF, 8'd255, 8'd255};
        3: cfg = {16'($urandom_range(60)), -16'($urandom_range(60)),
                  -16'($urandom_range(150)), -16'($urandom_range(300, 150)),
                  16'($urandom_range(450, 300)), 16'($urandom_range(600, 450)),
                  8'd1, 8'd1};
        4: cfg = {-16'sd5, 16'sd5, 16'($urandom_range(100)) - 16'd50,
                  16'($urandom_range(100)) - 16'd150, 16'($urandom_range(400, 200)),
                  16'($urandom_range(500, 300)), 8'($urandom_range(4, 2)),
                  8'($urandom_range(20))};
        default: cfg = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 8'($urandom_range(8, 1)),
                        8'($urandom_range(30))};
      endcase
      load_config(cfg);
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end
    drain();

    $display("Covered %0d active ticks, %0d frozen ticks and %0d reads", ticks_sent,
             frozen_sent, reads_sent);
    $display("over %0d register settings with all four idling patterns", PHASES + 1);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== battery_usage_statistics_logger_top.f =====
hw/rtl/bul_pkg.sv
hw/rtl/bul_if.sv
hw/rtl/bul_stats.sv
hw/rtl/battery_usage_statistics_logger_top.sv
hw/rtl/bul_checker.sv
dv/bul_usage_checker.sv
dv/tb_battery_usage_statistics_logger_top.sv
